// ----- src/lbac_pkg.sv -----
package lbac_pkg;

  localparam int unsigned SectorBitsDefault = 28;

  localparam int unsigned HeadW    = 5;
  localparam int unsigned SptW     = 6;
  localparam int unsigned PerCylW  = HeadW + SptW;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SideW    = 2 * ByteW;

  typedef enum logic [CfgIdxW-1:0] {
    RegHeadCount      = 3'd0,
    RegSectorsPerTrk  = 3'd1,
    RegDriveHeadBase  = 3'd2,
    RegPrecomp        = 3'd3
  } cfg_reg_e;

  localparam logic [HeadW-1:0] HeadCountReset     = 5'd16;
  localparam logic [SptW-1:0]  SptReset           = 6'd63;
  localparam logic [ByteW-1:0] DriveHeadBaseReset = 8'd160;
  localparam logic [ByteW-1:0] PrecompReset       = 8'd0;
  localparam logic [HeadW-1:0] EightHeadsMin      = 5'd8;

  typedef struct packed {
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] count;
  } side_t;

endpackage

// ----- src/lba_to_chs_task_file_core.sv -----
// Builds the task-file bytes of a disk command from a logical sector number.
// A command is taken when start is high and busy is low; busy is always low,
// so a new command may be given in every cycle. The cylinder comes out of a
// chain of SECTOR_BITS long-division cells dividing the sector by heads
// times sectors per track, one quotient bit per cell. A second chain of
// eleven cells divides the remainder by sectors per track for the head and
// sector. After an output register, the result is on the output ports for
// exactly one cycle with done_o high; one result leaves in every cycle.
// The receiver cannot hold results off and must take each transfer in the
// cycle it is shown. Registers are written through the cfg_we_i port and
// must only change while no command is in flight.
// Reset clears the pipeline and loads 16 heads, 63 sectors per track, a
// drive/head base of 0xA0 and zero precompensation.
module lba_to_chs_task_file_core #(
  parameter int unsigned SECTOR_BITS = lbac_pkg::SectorBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [SECTOR_BITS-1:0]        logical_sector_i,
  input  logic [lbac_pkg::ByteW-1:0]    command_code_i,
  input  logic [lbac_pkg::ByteW-1:0]    sector_count_i,
  input  logic                          cfg_we_i,
  input  logic [lbac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lbac_pkg::ByteW-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [lbac_pkg::SptW-1:0]     sector_byte_o,
  output logic [lbac_pkg::ByteW-1:0]    cylinder_low_o,
  output logic [lbac_pkg::ByteW-1:0]    cylinder_high_o,
  output logic [lbac_pkg::ByteW-1:0]    drive_head_byte_o,
  output logic [lbac_pkg::ByteW-1:0]    count_byte_o,
  output logic [lbac_pkg::ByteW-1:0]    command_byte_o,
  output logic [lbac_pkg::ByteW-1:0]    precomp_byte_o,
  output logic                          eight_heads_o,
  output logic                          cylinder_overflow_o
);

  localparam int unsigned HeadW   = lbac_pkg::HeadW;
  localparam int unsigned SptW    = lbac_pkg::SptW;
  localparam int unsigned PerCylW = lbac_pkg::PerCylW;
  localparam int unsigned ByteW   = lbac_pkg::ByteW;
  localparam int unsigned SideW   = lbac_pkg::SideW;
  localparam int unsigned Side2W  = SECTOR_BITS + SideW;

  logic [HeadW-1:0] head_count_q;
  logic [SptW-1:0]  spt_q;
  logic [ByteW-1:0] drive_head_base_q;
  logic [ByteW-1:0] precomp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_count_q      <= lbac_pkg::HeadCountReset;
      spt_q             <= lbac_pkg::SptReset;
      drive_head_base_q <= lbac_pkg::DriveHeadBaseReset;
      precomp_q         <= lbac_pkg::PrecompReset;
    end else if (cfg_we_i) begin
      case (lbac_pkg::cfg_reg_e'(cfg_idx_i))
        lbac_pkg::RegHeadCount:     head_count_q      <= cfg_wdata_i[HeadW-1:0];
        lbac_pkg::RegSectorsPerTrk: spt_q             <= cfg_wdata_i[SptW-1:0];
        lbac_pkg::RegDriveHeadBase: drive_head_base_q <= cfg_wdata_i;
        lbac_pkg::RegPrecomp:       precomp_q         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [HeadW-1:0]   heads_eff;
  logic [SptW-1:0]    spt_eff;
  logic [PerCylW-1:0] per_cyl;

  // A zero head count or zero sectors per track divides as one.
  always_comb begin
    heads_eff = (head_count_q == '0) ? HeadW'(1) : head_count_q;
    spt_eff   = (spt_q == '0) ? SptW'(1) : spt_q;
    per_cyl   = PerCylW'(heads_eff) * PerCylW'(spt_eff);
  end

  lbac_pkg::side_t     side_in;
  logic                accept;
  logic                c1_valid;
  logic [SECTOR_BITS-1:0] cylinder;
  logic [PerCylW-1:0]  rest;
  logic [SideW-1:0]    c1_side;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign side_in = '{command: command_code_i, count: sector_count_i};

  lbac_div_chain #(
    .DW(SECTOR_BITS),
    .RW(PerCylW),
    .SW(SideW)
  ) u_cyl_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .dividend_i (logical_sector_i),
    .divisor_i  (per_cyl),
    .side_i     (side_in),
    .valid_o    (c1_valid),
    .quotient_o (cylinder),
    .remainder_o(rest),
    .side_o     (c1_side)
  );

  logic               c2_valid;
  logic [PerCylW-1:0] head_q2;
  logic [SptW-1:0]    sec;
  logic [Side2W-1:0]  c2_side;

  lbac_div_chain #(
    .DW(PerCylW),
    .RW(SptW),
    .SW(Side2W)
  ) u_head_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (c1_valid),
    .dividend_i (rest),
    .divisor_i  (spt_eff),
    .side_i     ({cylinder, c1_side}),
    .valid_o    (c2_valid),
    .quotient_o (head_q2),
    .remainder_o(sec),
    .side_o     (c2_side)
  );

  logic [SECTOR_BITS-1:0] cyl_out;
  lbac_pkg::side_t        side_out;

  assign cyl_out  = c2_side[Side2W-1:SideW];
  assign side_out = lbac_pkg::side_t'(c2_side[SideW-1:0]);

  logic             done_q;
  logic [SptW-1:0]  sector_byte_q;
  logic [ByteW-1:0] cyl_low_q, cyl_high_q, dh_byte_q, count_q, command_q;
  logic             overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_byte_q <= sec + SptW'(1);
    cyl_low_q     <= cyl_out[ByteW-1:0];
    cyl_high_q    <= cyl_out[2*ByteW-1:ByteW];
    dh_byte_q     <= drive_head_base_q | head_q2[ByteW-1:0];
    count_q       <= side_out.count;
    command_q     <= side_out.command;
    overflow_q    <= (cyl_out >> (2 * ByteW)) != '0;
  end

  assign done_o              = done_q;
  assign sector_byte_o       = sector_byte_q;
  assign cylinder_low_o      = cyl_low_q;
  assign cylinder_high_o     = cyl_high_q;
  assign drive_head_byte_o   = dh_byte_q;
  assign count_byte_o        = count_q;
  assign command_byte_o      = command_q;
  assign precomp_byte_o      = precomp_q;
  assign eight_heads_o       = head_count_q >= lbac_pkg::EightHeadsMin;
  assign cylinder_overflow_o = overflow_q;

  a_sector_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sector_byte_o != '0))
    else $error("sector byte is zero");

  a_sector_in_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sector_byte_o <= spt_eff))
    else $error("sector byte beyond track length");

  a_head_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_valid |-> (head_q2 < PerCylW'(heads_eff)))
    else $error("head number not below head count");

  a_base_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((drive_head_byte_o & drive_head_base_q) == drive_head_base_q))
    else $error("drive/head byte lost base bits");

endmodule

// ----- src/lbac_div_cell.sv -----
module lbac_div_cell #(
  parameter int unsigned DW = 28,
  parameter int unsigned RW = 11,
  parameter int unsigned SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] dq_i,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] dq_o,
  output logic [RW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [DW-1:0] dq_q, dq_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [SW-1:0] side_q;
  logic [RW:0]   shifted;
  logic [RW:0]   diff;
  logic          ge;

  // One restoring long-division step: shift in the next dividend bit and
  // subtract the divisor when it fits, shifting the quotient bit in behind.
  always_comb begin
    shifted = {rem_i, dq_i[DW-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
    rem_d   = ge ? diff[RW-1:0] : shifted[RW-1:0];
    dq_d    = {dq_i[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign dq_o    = dq_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q < divisor_i))
    else $error("partial remainder not below divisor");

endmodule

// ----- src/lbac_div_chain.sv -----
module lbac_div_chain #(
  parameter int unsigned DW = 28,
  parameter int unsigned RW = 11,
  parameter int unsigned SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quotient_o,
  output logic [RW-1:0] remainder_o,
  output logic [SW-1:0] side_o
);

  logic          valid_s [DW+1];
  logic [DW-1:0] dq_s    [DW+1];
  logic [RW-1:0] rem_s   [DW+1];
  logic [SW-1:0] side_s  [DW+1];

  assign valid_s[0] = valid_i;
  assign dq_s[0]    = dividend_i;
  assign rem_s[0]   = '0;
  assign side_s[0]  = side_i;

  for (genvar g = 0; g < DW; g++) begin : g_cell
    lbac_div_cell #(
      .DW(DW),
      .RW(RW),
      .SW(SW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_s[g]),
      .dq_i     (dq_s[g]),
      .rem_i    (rem_s[g]),
      .divisor_i(divisor_i),
      .side_i   (side_s[g]),
      .valid_o  (valid_s[g+1]),
      .dq_o     (dq_s[g+1]),
      .rem_o    (rem_s[g+1]),
      .side_o   (side_s[g+1])
    );
  end

  assign valid_o     = valid_s[DW];
  assign quotient_o  = dq_s[DW];
  assign remainder_o = rem_s[DW];
  assign side_o      = side_s[DW];

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  localparam int unsigned SectorBits     = lbac_pkg::SectorBitsDefault;
  localparam int unsigned HeadW          = lbac_pkg::HeadW;
  localparam int unsigned SptW           = lbac_pkg::SptW;
  localparam int unsigned ByteW          = lbac_pkg::ByteW;
  localparam int unsigned CfgIdxW        = lbac_pkg::CfgIdxW;
  localparam int unsigned Latency        = SectorBits + 12;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned RandPhases     = 11;
  localparam int unsigned ItemsPerPhase  = 50;
  localparam int unsigned ReportLimit    = 10;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLastUnused  = 3'd7;

  typedef struct packed {
    logic [SptW-1:0]  sector;
    logic [ByteW-1:0] cyl_lo;
    logic [ByteW-1:0] cyl_hi;
    logic [ByteW-1:0] drive_head;
    logic [ByteW-1:0] count;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] precomp;
    logic             eight_heads;
    logic             overflow;
  } task_file_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  start            = 1'b0;
  logic [SectorBits-1:0] logical_sector_i = '0;
  logic [ByteW-1:0]      command_code_i   = '0;
  logic [ByteW-1:0]      sector_count_i   = '0;
  logic                  cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i        = '0;
  logic [ByteW-1:0]      cfg_wdata_i      = '0;
  logic                  busy;
  logic                  done_o;
  logic [SptW-1:0]       sector_byte_o;
  logic [ByteW-1:0]      cylinder_low_o;
  logic [ByteW-1:0]      cylinder_high_o;
  logic [ByteW-1:0]      drive_head_byte_o;
  logic [ByteW-1:0]      count_byte_o;
  logic [ByteW-1:0]      command_byte_o;
  logic [ByteW-1:0]      precomp_byte_o;
  logic                  eight_heads_o;
  logic                  cylinder_overflow_o;

  logic [HeadW-1:0] cfg_heads   = lbac_pkg::HeadCountReset;
  logic [SptW-1:0]  cfg_spt     = lbac_pkg::SptReset;
  logic [ByteW-1:0] cfg_dh_base = lbac_pkg::DriveHeadBaseReset;
  logic [ByteW-1:0] cfg_precomp = lbac_pkg::PrecompReset;

  task_file_t  task_file_q[$];
  int unsigned error_cnt     = 0;
  int unsigned commands_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned geometries    = 1;
  int unsigned cycle_cnt     = 0;
  bit          gaps_on       = 1'b1;

  lba_to_chs_task_file_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .logical_sector_i   (logical_sector_i),
    .command_code_i     (command_code_i),
    .sector_count_i     (sector_count_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .sector_byte_o      (sector_byte_o),
    .cylinder_low_o     (cylinder_low_o),
    .cylinder_high_o    (cylinder_high_o),
    .drive_head_byte_o  (drive_head_byte_o),
    .count_byte_o       (count_byte_o),
    .command_byte_o     (command_byte_o),
    .precomp_byte_o     (precomp_byte_o),
    .eight_heads_o      (eight_heads_o),
    .cylinder_overflow_o(cylinder_overflow_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] cylinder_size();
    logic [31:0] heads;
    logic [31:0] spt;
    heads = (cfg_heads == '0) ? 32'd1 : 32'(cfg_heads);
    spt   = (cfg_spt == '0) ? 32'd1 : 32'(cfg_spt);
    return heads * spt;
  endfunction

  function automatic task_file_t predict_task_file(input logic [SectorBits-1:0] lba,
                                                   input logic [ByteW-1:0] cmd,
                                                   input logic [ByteW-1:0] cnt);
    task_file_t  tf;
    logic [31:0] spt;
    logic [31:0] cyl;
    logic [31:0] rest;
    logic [31:0] head;
    logic [31:0] sec1;
    spt  = (cfg_spt == '0) ? 32'd1 : 32'(cfg_spt);
    cyl  = 32'(lba) / cylinder_size();
    rest = 32'(lba) % cylinder_size();
    head = rest / spt;
    sec1 = rest % spt + 32'd1;
    tf.sector      = sec1[SptW-1:0];
    tf.cyl_lo      = cyl[7:0];
    tf.cyl_hi      = cyl[15:8];
    tf.drive_head  = cfg_dh_base | head[ByteW-1:0];
    tf.count       = cnt;
    tf.command     = cmd;
    tf.precomp     = cfg_precomp;
    tf.eight_heads = (cfg_heads >= lbac_pkg::EightHeadsMin);
    tf.overflow    = (cyl > 32'hFFFF);
    return tf;
  endfunction

  task automatic report_error(input string what, input int unsigned exp, input int unsigned act);
    error_cnt++;
    if (error_cnt <= ReportLimit) begin
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, exp, act);
    end
  endtask

  task automatic check_field(input string what, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      report_error(what, exp, act);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    task_file_t got;
    task_file_t exp;
    if (!rst_ni) begin
      cfg_heads   = lbac_pkg::HeadCountReset;
      cfg_spt     = lbac_pkg::SptReset;
      cfg_dh_base = lbac_pkg::DriveHeadBaseReset;
      cfg_precomp = lbac_pkg::PrecompReset;
    end else begin
      if (done_o) begin
        got = '{sector_byte_o, cylinder_low_o, cylinder_high_o, drive_head_byte_o,
                count_byte_o, command_byte_o, precomp_byte_o, eight_heads_o,
                cylinder_overflow_o};
        results_seen++;
        if (task_file_q.size() == 0) begin
          report_error("unexpected transfer", 0, 1);
        end else begin
          exp = task_file_q.pop_front();
          check_field("sector_byte", exp.sector, got.sector);
          check_field("cylinder_low", exp.cyl_lo, got.cyl_lo);
          check_field("cylinder_high", exp.cyl_hi, got.cyl_hi);
          check_field("drive_head_byte", exp.drive_head, got.drive_head);
          check_field("count_byte", exp.count, got.count);
          check_field("command_byte", exp.command, got.command);
          check_field("precomp_byte", exp.precomp, got.precomp);
          check_field("eight_heads", exp.eight_heads, got.eight_heads);
          check_field("cylinder_overflow", exp.overflow, got.overflow);
        end
      end
      if (start && !busy) begin
        task_file_q.push_back(predict_task_file(logical_sector_i, command_code_i,
                                                sector_count_i));
        commands_sent++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lbac_pkg::RegHeadCount:     cfg_heads   = cfg_wdata_i[HeadW-1:0];
          lbac_pkg::RegSectorsPerTrk: cfg_spt     = cfg_wdata_i[SptW-1:0];
          lbac_pkg::RegDriveHeadBase: cfg_dh_base = cfg_wdata_i;
          lbac_pkg::RegPrecomp:       cfg_precomp = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  task automatic send_command(input logic [SectorBits-1:0] lba,
                              input logic [ByteW-1:0] cmd,
                              input logic [ByteW-1:0] cnt);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    logical_sector_i <= lba;
    command_code_i   <= cmd;
    sector_count_i   <= cnt;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (task_file_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [ByteW-1:0] heads, input logic [ByteW-1:0] spt,
                              input logic [ByteW-1:0] dh_base, input logic [ByteW-1:0] precomp);
    wait_idle();
    write_reg(lbac_pkg::RegHeadCount, heads);
    write_reg(lbac_pkg::RegSectorsPerTrk, spt);
    write_reg(lbac_pkg::RegDriveHeadBase, dh_base);
    write_reg(lbac_pkg::RegPrecomp, precomp);
    geometries++;
  endtask

  function automatic logic [SectorBits-1:0] pick_lba();
    logic [31:0] per_cyl;
    logic [31:0] v;
    per_cyl = cylinder_size();
    case ($urandom_range(0, 3))
      0:       v = $urandom;
      1:       v = per_cyl * 32'h10000 - per_cyl + $urandom_range(0, 2 * per_cyl);
      2:       v = per_cyl * $urandom_range(0, 300) + $urandom_range(0, per_cyl - 1);
      default: v = $urandom_range(0, 4095);
    endcase
    return v[SectorBits-1:0];
  endfunction

  task automatic test_default_geometry();
    send_command('0, 8'h00, 8'h00);
    send_command('1, 8'hFF, 8'hFF);
    send_command(28'd62, 8'hC4, 8'h01);
    send_command(28'd1007, 8'h20, 8'h10);
    send_command(28'd1008, 8'h30, 8'h80);
    send_command(28'd66061287, 8'h5A, 8'hA5);
    send_command(28'd66060288, 8'hA5, 8'h5A);
  endtask

  task automatic test_zero_geometry();
    set_geometry(8'hE0, 8'hC0, 8'h5A, 8'hA5);
    send_command('0, 8'h24, 8'h02);
    send_command(28'd12345, 8'h34, 8'h03);
    send_command('1, 8'hC8, 8'hFE);
  endtask

  task automatic test_wide_heads();
    set_geometry(8'hFF, 8'h3F, 8'h00, 8'hFF);
    send_command(28'd1952, 8'h20, 8'h01);
    send_command(28'd1953, 8'h30, 8'h7F);
    send_command(28'hAAAAAAA, 8'hAA, 8'h55);
    send_command(28'h5555555, 8'h55, 8'hAA);
  endtask

  task automatic test_unused_index();
    wait_idle();
    for (int idx = RegFirstUnused; idx <= RegLastUnused; idx++) begin
      write_reg(idx[CfgIdxW-1:0], 8'($urandom));
    end
    send_command(28'd1952, 8'hEC, 8'h00);
    send_command(28'd100000, 8'hCA, 8'h08);
    send_command('1, 8'h91, 8'h3F);
  endtask

  task automatic test_cylinder_wrap();
    set_geometry(8'h01, 8'h01, 8'hA0, 8'h00);
    send_command(28'd65535, 8'h20, 8'h01);
    send_command(28'd65536, 8'h20, 8'h01);
    send_command(28'h000FF00, 8'h30, 8'h02);
    send_command('1, 8'h30, 8'h02);
  endtask

  task automatic test_random_geometry();
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       set_geometry(8'h01, 8'h01, 8'h00, 8'h00);
        1:       set_geometry(8'h1F, 8'h3F, 8'hFF, 8'hFF);
        2:       set_geometry(8'h10, 8'h3F, 8'hA0, 8'h00);
        default: set_geometry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i % 10 == 0) begin
          gaps_on = ($urandom_range(0, 3) != 0);
        end
        send_command(pick_lba(), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_geometry();
    test_zero_geometry();
    test_wide_heads();
    test_unused_index();
    test_cylinder_wrap();
    test_random_geometry();
    wait_idle();
    repeat (Latency + 10) @(posedge clk_i);
    $display("Converted %0d commands and checked %0d transfers under %0d drive geometries,",
             commands_sent, results_seen, geometries);
    $display("including zero, oversized and minimal geometries and wrapped cylinders.");
    if (error_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lbac_pkg.sv
src/lbac_div_cell.sv
src/lbac_div_chain.sv
src/lba_to_chs_task_file_core.sv
tb/tb_top.sv
